// ===== rtl/packet_deframer_additive_checksum_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the packet deframer
// Shared property wrappers, compiled out when NO_ASSERTIONS is set.
// ----------------------------------------------------------------------------
`ifndef PACKET_DEFRAMER_ADDITIVE_CHECKSUM_DEFINES_SVH
`define PACKET_DEFRAMER_ADDITIVE_CHECKSUM_DEFINES_SVH

`ifndef NO_ASSERTIONS
// same-cycle implication
`define PDAC_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("pdac assertion failed");
// next-cycle implication
`define PDAC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("pdac assertion failed");
`else
`define PDAC_ASSERT_IMPLY(label, ante, cons)
`define PDAC_ASSERT_NEXT(label, ante, cons)
`endif

`endif

// ===== rtl/pdac_pkg.sv =====
// ----------------------------------------------------------------------------
// pdac_pkg
// Types and constants shared by the packet deframer modules.
// ----------------------------------------------------------------------------
`default_nettype none

package pdac_pkg;

    localparam int MAX_PAYLOAD = 32;
    localparam int IDX_W       = $clog2(MAX_PAYLOAD);
    localparam int LEN_W       = $clog2(MAX_PAYLOAD + 1);
    localparam int RAM_DEPTH   = 2 * MAX_PAYLOAD;     // two packet buffers
    localparam int RAM_AW      = IDX_W + 1;
    localparam int M_TDATA_W   = 32;
    localparam int TDATA_PAD   = M_TDATA_W - (8 + LEN_W + IDX_W + 8);

    // configuration register indexes
    localparam logic CFG_FIRST_START  = 1'b0;
    localparam logic CFG_SECOND_START = 1'b1;

    typedef enum logic [2:0] {
        P_HUNT1,
        P_HUNT2,
        P_ID,
        P_LEN,
        P_DATA,
        P_SUM
    } phase_t;

    typedef enum logic [1:0] {
        B_IDLE,
        B_READ,
        B_SHOW
    } back_state_t;

    // one good packet waiting to be drained
    typedef struct packed {
        logic [7:0]       msg_id;
        logic [LEN_W-1:0] len;
        logic             bank;
    } desc_t;

    typedef struct packed {
        logic  valid;
        desc_t desc;
    } push_t;

    typedef struct packed {
        logic empty;
        logic full;
    } qstat_t;

    typedef struct packed {
        logic              en;
        logic [RAM_AW-1:0] addr;
        logic [7:0]        data;
    } ram_wr_t;

endpackage

`default_nettype wire

// ===== rtl/pdac_ram.sv =====
// ----------------------------------------------------------------------------
// pdac_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pdac_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     aclk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pdac_front.sv =====
// ----------------------------------------------------------------------------
// pdac_front
// Frame parser: hunts start bytes, buffers payload, checks the sum and
// queues a descriptor for every good frame.
// ----------------------------------------------------------------------------
`default_nettype none

module pdac_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             cfg_wr_en,
    input  wire logic             cfg_addr,
    input  wire logic [7:0]       cfg_wr_data,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [7:0]       s_tdata,
    input  wire logic             s_tuser,
    input  wire pdac_pkg::qstat_t q_stat,
    output pdac_pkg::push_t       q_push,
    output pdac_pkg::ram_wr_t     ram_wr
);

    pdac_pkg::phase_t             phase_reg, phase_next;
    logic [7:0]                   first_reg, second_reg;
    logic [7:0]                   id_reg, id_next;
    logic [pdac_pkg::LEN_W-1:0]   len_reg, len_next;
    logic [pdac_pkg::LEN_W-1:0]   fill_reg, fill_next;
    logic [7:0]                   sum_reg, sum_next;
    logic                         bank_reg, bank_next;
    logic                         accept;
    logic [pdac_pkg::LEN_W-1:0]   fill_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            first_reg  <= 8'd170;
            second_reg <= 8'd175;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                pdac_pkg::CFG_FIRST_START:  first_reg  <= cfg_wr_data;
                pdac_pkg::CFG_SECOND_START: second_reg <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= pdac_pkg::P_HUNT1;
            id_reg    <= '0;
            len_reg   <= '0;
            fill_reg  <= '0;
            sum_reg   <= '0;
            bank_reg  <= 1'b0;
        end else begin
            phase_reg <= phase_next;
            id_reg    <= id_next;
            len_reg   <= len_next;
            fill_reg  <= fill_next;
            sum_reg   <= sum_next;
            bank_reg  <= bank_next;
        end
    end

    // both buffers held: no payload writes and no push until the back drains one
    assign s_tready = !(q_stat.full &&
                        (phase_reg inside {pdac_pkg::P_DATA, pdac_pkg::P_SUM}));
    assign accept   = s_tvalid && s_tready;
    assign fill_inc = fill_reg + 1'b1;

    always_comb begin
        phase_next   = phase_reg;
        id_next      = id_reg;
        len_next     = len_reg;
        fill_next    = fill_reg;
        sum_next     = sum_reg;
        bank_next    = bank_reg;
        q_push.valid = 1'b0;
        q_push.desc.msg_id = id_reg;
        q_push.desc.len    = len_reg;
        q_push.desc.bank   = bank_reg;
        ram_wr.en    = 1'b0;
        ram_wr.addr  = {bank_reg, fill_reg[pdac_pkg::IDX_W-1:0]};
        ram_wr.data  = s_tdata;
        if (accept) begin
            if (s_tuser) begin
                phase_next = pdac_pkg::P_HUNT1;
            end else begin
                case (phase_reg)
                    pdac_pkg::P_HUNT1: begin
                        sum_next   = s_tdata;
                        phase_next = (s_tdata == first_reg) ? pdac_pkg::P_HUNT2
                                                            : pdac_pkg::P_HUNT1;
                    end
                    pdac_pkg::P_HUNT2: begin
                        sum_next   = sum_reg + s_tdata;
                        phase_next = (s_tdata == second_reg) ? pdac_pkg::P_ID
                                                             : pdac_pkg::P_HUNT1;
                    end
                    pdac_pkg::P_ID: begin
                        id_next    = s_tdata;
                        sum_next   = sum_reg + s_tdata;
                        phase_next = pdac_pkg::P_LEN;
                    end
                    pdac_pkg::P_LEN: begin
                        if (s_tdata <= 8'(pdac_pkg::MAX_PAYLOAD)) begin
                            len_next   = s_tdata[pdac_pkg::LEN_W-1:0];
                            fill_next  = '0;
                            sum_next   = sum_reg + s_tdata;
                            phase_next = (s_tdata != 8'd0) ? pdac_pkg::P_DATA
                                                           : pdac_pkg::P_SUM;
                        end else begin
                            phase_next = pdac_pkg::P_HUNT1;
                        end
                    end
                    pdac_pkg::P_DATA: begin
                        ram_wr.en = 1'b1;
                        fill_next = fill_inc;
                        sum_next  = sum_reg + s_tdata;
                        if (fill_inc >= len_reg) begin
                            phase_next = pdac_pkg::P_SUM;
                        end
                    end
                    pdac_pkg::P_SUM: begin
                        if (sum_reg == s_tdata) begin
                            q_push.valid = 1'b1;
                            bank_next    = !bank_reg;
                        end
                        phase_next = pdac_pkg::P_HUNT1;
                    end
                    default: phase_next = pdac_pkg::P_HUNT1;
                endcase
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/pdac_queue.sv =====
// ----------------------------------------------------------------------------
// pdac_queue
// Two-entry descriptor FIFO between parser and drain.
// ----------------------------------------------------------------------------
`default_nettype none

module pdac_queue (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire pdac_pkg::push_t q_push,
    input  wire logic            q_pop,
    output pdac_pkg::desc_t      q_head,
    output pdac_pkg::qstat_t     q_stat
);

    pdac_pkg::desc_t entry_reg [2];
    logic            wr_ptr_reg, rd_ptr_reg;
    logic [1:0]      count_reg, count_next;

    always_ff @(posedge aclk) begin
        if (q_push.valid) begin
            entry_reg[wr_ptr_reg] <= q_push.desc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (q_push.valid) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (q_pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            count_reg <= count_next;
        end
    end

    always_comb begin
        count_next = count_reg;
        case ({q_push.valid, q_pop})
            2'b10:   count_next = count_reg + 2'd1;
            2'b01:   count_next = count_reg - 2'd1;
            default: count_next = count_reg;
        endcase
    end

    assign q_head       = entry_reg[rd_ptr_reg];
    assign q_stat.empty = (count_reg == 2'd0);
    assign q_stat.full  = (count_reg == 2'd2);

endmodule

`default_nettype wire

// ===== rtl/pdac_back.sv =====
// ----------------------------------------------------------------------------
// pdac_back
// Packet drain: reads the buffered payload of the head descriptor and presents
// one result per byte (one for an empty packet) through an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module pdac_back (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire pdac_pkg::desc_t               q_head,
    input  wire pdac_pkg::qstat_t              q_stat,
    output logic                               q_pop,
    output logic                               rd_en,
    output logic [pdac_pkg::RAM_AW-1:0]        rd_addr,
    input  wire logic [7:0]                    rd_data,
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    output logic [pdac_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser,
    output logic                               m_tlast
);

    pdac_pkg::back_state_t      state_reg, state_next;
    logic [pdac_pkg::IDX_W-1:0] idx_reg, idx_next;
    logic                       valid_reg, valid_next;
    logic [7:0]                 id_reg, id_next;
    logic [pdac_pkg::LEN_W-1:0] len_reg, len_next;
    logic [pdac_pkg::IDX_W-1:0] oidx_reg, oidx_next;
    logic [7:0]                 data_reg, data_next;
    logic                       has_reg, has_next;
    logic                       last_reg, last_next;
    logic [pdac_pkg::LEN_W-1:0] idx_inc;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdac_pkg::B_IDLE;
            valid_reg <= 1'b0;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg   <= id_next;
        len_reg  <= len_next;
        oidx_reg <= oidx_next;
        data_reg <= data_next;
        has_reg  <= has_next;
        last_reg <= last_next;
    end

    assign idx_inc = {1'b0, idx_reg} + 1'b1;

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        valid_next = valid_reg;
        id_next    = id_reg;
        len_next   = len_reg;
        oidx_next  = oidx_reg;
        data_next  = data_reg;
        has_next   = has_reg;
        last_next  = last_reg;
        q_pop      = 1'b0;
        rd_en      = 1'b0;
        rd_addr    = {q_head.bank, idx_reg};
        case (state_reg)
            pdac_pkg::B_IDLE: begin
                if (!q_stat.empty) begin
                    idx_next   = '0;
                    rd_en      = 1'b1;
                    rd_addr    = {q_head.bank, {pdac_pkg::IDX_W{1'b0}}};
                    state_next = pdac_pkg::B_READ;
                end
            end
            pdac_pkg::B_READ: begin
                // read data for idx_reg is on rd_data now
                valid_next = 1'b1;
                id_next    = q_head.msg_id;
                len_next   = q_head.len;
                oidx_next  = idx_reg;
                has_next   = (q_head.len != '0);
                data_next  = (q_head.len != '0) ? rd_data : 8'd0;
                last_next  = (q_head.len == '0) || (idx_inc == q_head.len);
                state_next = pdac_pkg::B_SHOW;
            end
            pdac_pkg::B_SHOW: begin
                if (m_tready) begin
                    valid_next = 1'b0;
                    if (last_reg) begin
                        q_pop      = 1'b1;
                        state_next = pdac_pkg::B_IDLE;
                    end else begin
                        idx_next   = idx_inc[pdac_pkg::IDX_W-1:0];
                        rd_en      = 1'b1;
                        rd_addr    = {q_head.bank, idx_inc[pdac_pkg::IDX_W-1:0]};
                        state_next = pdac_pkg::B_READ;
                    end
                end
            end
            default: state_next = pdac_pkg::B_IDLE;
        endcase
    end

    assign m_tvalid = valid_reg;
    assign m_tuser  = has_reg;
    assign m_tlast  = last_reg;
    assign m_tdata  = {{pdac_pkg::TDATA_PAD{1'b0}}, data_reg, oidx_reg, len_reg, id_reg};

endmodule

`default_nettype wire

// ===== rtl/packet_deframer_additive_checksum.sv =====
// Parser takes one byte or timeout per cycle; it stalls only in payload or
// checksum phase while both payload buffers hold undrained packets.
// A good frame's descriptor is queued on its checksum byte; the drain reads each
// byte (registered RAM read, then output register) and the next once the result
// is taken. Reset (aresetn low, synchronous) clears parser, queue and drain
// state and loads start bytes 170/175; the payload RAM is not cleared.
// ----------------------------------------------------------------------------
// packet_deframer_additive_checksum
// Byte-stream deframer with 8-bit additive checksum and double-buffered
// payload drain.
// ----------------------------------------------------------------------------
`default_nettype none

`include "packet_deframer_additive_checksum_defines.svh"

module packet_deframer_additive_checksum (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // configuration write
    input  wire logic                          cfg_wr_en,
    input  wire logic                          cfg_addr,
    input  wire logic [7:0]                    cfg_wr_data,
    // input stream
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [7:0]                    s_tdata,   // rx_byte[7:0]
    input  wire logic                          s_tuser,   // mode
    // result stream
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // msg_id[7:0], payload_len[13:8], byte_index[18:14], data_byte[26:19], zero
    output logic [pdac_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                               m_tuser,   // has_data
    output logic                               m_tlast    // last
);

    pdac_pkg::push_t               q_push;
    pdac_pkg::qstat_t              q_stat;
    pdac_pkg::desc_t               q_head;
    pdac_pkg::ram_wr_t             ram_wr;
    logic                          q_pop;
    logic                          rd_en;
    logic [pdac_pkg::RAM_AW-1:0]   rd_addr;
    logic [7:0]                    rd_data;

    pdac_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .q_stat      (q_stat),
        .q_push      (q_push),
        .ram_wr      (ram_wr)
    );

    pdac_ram #(
        .WIDTH (8),
        .DEPTH (pdac_pkg::RAM_DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr.en),
        .wr_addr (ram_wr.addr),
        .wr_data (ram_wr.data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    pdac_queue u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_push  (q_push),
        .q_pop   (q_pop),
        .q_head  (q_head),
        .q_stat  (q_stat)
    );

    pdac_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_head   (q_head),
        .q_stat   (q_stat),
        .q_pop    (q_pop),
        .rd_en    (rd_en),
        .rd_addr  (rd_addr),
        .rd_data  (rd_data),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    `PDAC_ASSERT_IMPLY(a_no_push_when_full, q_push.valid, !q_stat.full)
    `PDAC_ASSERT_IMPLY(a_pop_on_last_transfer, q_pop, m_tvalid && m_tready && m_tlast)
    `PDAC_ASSERT_IMPLY(a_result_has_packet, m_tvalid, !q_stat.empty)
    `PDAC_ASSERT_IMPLY(a_empty_packet_shape, m_tvalid && !m_tuser, m_tlast && (m_tdata[18:14] == 5'd0))

endmodule

`default_nettype wire

// ===== tb/packet_deframer_additive_checksum_tb.sv =====
// ----------------------------------------------------------------------------
// packet_deframer_additive_checksum_tb
// Drives framed and broken byte streams into the deframer across several
// start-byte settings. A behavioral deframer predicts the packet runs (typed
// script rows give their own); each result transfer is checked field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module packet_deframer_additive_checksum_tb;

    localparam logic [7:0] RST_FIRST  = 8'hAA;
    localparam logic [7:0] RST_SECOND = 8'hAF;

    typedef struct packed {
        logic [7:0]                 msg_id;
        logic [pdac_pkg::LEN_W-1:0] payload_len;
        logic                       has_data;
        logic [pdac_pkg::IDX_W-1:0] byte_index;
        logic [7:0]                 data_byte;
        logic                       last;
    } beat_t;

    // one directed transfer; typed rows carry their own expectation
    typedef struct packed {
        logic       md;
        logic [7:0] b;
        logic       typed;
        logic       one_beat;
        beat_t      beat;
    } row_t;

    typedef enum logic [2:0] {
        FLAW_NONE,
        FLAW_SUM,
        FLAW_SECOND,
        FLAW_OVERSIZE,
        FLAW_TIMEOUT
    } frame_flaw_t;

    localparam beat_t NO_BEAT = '0;

    logic                            aclk        = 1'b0;
    logic                            aresetn     = 1'b0;
    logic                            cfg_wr_en   = 1'b0;
    logic                            cfg_addr    = pdac_pkg::CFG_FIRST_START;
    logic [7:0]                      cfg_wr_data = 8'h00;
    logic                            s_tvalid    = 1'b0;
    logic                            s_tready;
    logic [7:0]                      s_tdata     = 8'h00;
    logic                            s_tuser     = 1'b0;
    logic                            m_tvalid;
    logic                            m_tready    = 1'b0;
    logic [pdac_pkg::M_TDATA_W-1:0]  m_tdata;
    logic                            m_tuser;
    logic                            m_tlast;

    packet_deframer_additive_checksum dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // behavioral deframer state
    logic [7:0]                 first_start  = RST_FIRST;
    logic [7:0]                 second_start = RST_SECOND;
    pdac_pkg::phase_t           pr_phase     = pdac_pkg::P_HUNT1;
    logic [7:0]                 pr_msg_id    = 8'h00;
    logic [pdac_pkg::LEN_W-1:0] pr_len       = '0;
    logic [pdac_pkg::LEN_W-1:0] pr_fill      = '0;
    logic [7:0]                 pr_sum       = 8'h00;
    logic [7:0]                 pr_store [0:pdac_pkg::MAX_PAYLOAD-1];
    beat_t                      burst [0:pdac_pkg::MAX_PAYLOAD-1];

    beat_t pending_beats [$];
    int    mismatch_count = 0;
    int    items_sent     = 0;
    bit    no_gaps        = 1'b0;
    bit    pressure_go    = 1'b0;

    row_t script [0:25] = '{
        // empty packet after reset
        '{1'b0, 8'hAA, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'hAF, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'h00, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'h00, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'h59, 1'b1, 1'b1, '{8'h00, 6'd0, 1'b0, 5'd0, 8'h00, 1'b1}},
        // timeout in mid-frame
        '{1'b0, 8'hAA, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'hAF, 1'b0, 1'b0, NO_BEAT},
        '{1'b1, 8'hFF, 1'b1, 1'b0, NO_BEAT},
        // second start mismatch; the bad byte is not taken as a new first start
        '{1'b0, 8'hAA, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'hAA, 1'b1, 1'b0, NO_BEAT},
        '{1'b0, 8'hAF, 1'b1, 1'b0, NO_BEAT},
        // oversized length
        '{1'b0, 8'hAA, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'hAF, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'h21, 1'b1, 1'b0, NO_BEAT},
        // bad checksum
        '{1'b0, 8'hAA, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'hAF, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'h01, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'h00, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'h00, 1'b1, 1'b0, NO_BEAT},
        // one-byte payload, all ones
        '{1'b0, 8'hAA, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'hAF, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'h01, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'hFF, 1'b0, 1'b0, NO_BEAT},
        '{1'b0, 8'h58, 1'b1, 1'b1, '{8'hFF, 6'd1, 1'b1, 5'd0, 8'hFF, 1'b1}}
    };

    // advances the parser by one input and fills burst; returns the run length
    function automatic int deframe_byte(input logic md, input logic [7:0] b);
        int n;
        n = 0;
        if (md) begin
            pr_phase = pdac_pkg::P_HUNT1;
            return 0;
        end
        case (pr_phase)
            pdac_pkg::P_HUNT1: begin
                pr_phase = (b == first_start) ? pdac_pkg::P_HUNT2 : pdac_pkg::P_HUNT1;
                pr_sum   = b;
            end
            pdac_pkg::P_HUNT2: begin
                pr_phase = (b == second_start) ? pdac_pkg::P_ID : pdac_pkg::P_HUNT1;
                pr_sum   = pr_sum + b;
            end
            pdac_pkg::P_ID: begin
                pr_msg_id = b;
                pr_sum    = pr_sum + b;
                pr_phase  = pdac_pkg::P_LEN;
            end
            pdac_pkg::P_LEN: begin
                if (b <= pdac_pkg::MAX_PAYLOAD) begin
                    pr_len   = b[pdac_pkg::LEN_W-1:0];
                    pr_fill  = '0;
                    pr_sum   = pr_sum + b;
                    pr_phase = (b != 0) ? pdac_pkg::P_DATA : pdac_pkg::P_SUM;
                end else begin
                    pr_phase = pdac_pkg::P_HUNT1;
                end
            end
            pdac_pkg::P_DATA: begin
                pr_store[pr_fill[pdac_pkg::IDX_W-1:0]] = b;
                pr_fill = pr_fill + 1'b1;
                pr_sum  = pr_sum + b;
                if (pr_fill >= pr_len)
                    pr_phase = pdac_pkg::P_SUM;
            end
            pdac_pkg::P_SUM: begin
                if (pr_sum == b) begin
                    if (pr_len == 0) begin
                        burst[0] = '{pr_msg_id, pr_len, 1'b0, 5'd0, 8'h00, 1'b1};
                        n = 1;
                    end else begin
                        for (int i = 0; i < pr_len; i++)
                            burst[i] = '{pr_msg_id, pr_len, 1'b1,
                                         (pdac_pkg::IDX_W)'(i), pr_store[i],
                                         (i + 1 == pr_len)};
                        n = pr_len;
                    end
                end
                pr_phase = pdac_pkg::P_HUNT1;
            end
            default: begin
                pr_phase = pdac_pkg::P_HUNT1;
            end
        endcase
        return n;
    endfunction

    function automatic void check_field(input string name, input int unsigned want,
                                        input int unsigned got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            mismatch_count++;
        end
    endfunction

    // valid stays up after a transfer; the next call either idles or reloads it
    task automatic send_item(input logic md, input logic [7:0] b, input bit tally,
                             output int n);
        while (!no_gaps && $urandom_range(99) < 18) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= md;
        s_tdata  <= b;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        n = deframe_byte(md, b);
        if (tally)
            items_sent++;
    endtask

    task automatic feed(input logic md, input logic [7:0] b, input bit tally);
        int n;
        send_item(md, b, tally, n);
        for (int k = 0; k < n; k++)
            pending_beats.push_back(burst[k]);
    endtask

    task automatic send_frame(input frame_flaw_t flaw);
        logic [7:0] frame [$];
        logic [7:0] sum;
        int         len;
        int         r;
        int         cut;
        r = $urandom_range(99);
        if (r < 10)
            len = 0;
        else if (r < 20)
            len = pdac_pkg::MAX_PAYLOAD;
        else if (r < 30)
            len = $urandom_range(pdac_pkg::MAX_PAYLOAD, 1);
        else
            len = $urandom_range(6, 1);
        // resync most of the time so frames start from the hunt
        if (pr_phase != pdac_pkg::P_HUNT1 && $urandom_range(9) != 0)
            feed(1'b1, 8'($urandom), 1'b1);
        frame.push_back(first_start);
        frame.push_back(second_start);
        frame.push_back(8'($urandom));
        if (flaw == FLAW_OVERSIZE) begin
            frame.push_back(8'($urandom_range(255, pdac_pkg::MAX_PAYLOAD + 1)));
            len = $urandom_range(2);
        end else begin
            frame.push_back(8'(len));
        end
        for (int i = 0; i < len; i++)
            frame.push_back(8'($urandom));
        sum = 8'h00;
        foreach (frame[i])
            sum = sum + frame[i];
        frame.push_back(sum);
        if (flaw == FLAW_SUM)
            frame[frame.size() - 1] = sum ^ 8'($urandom_range(255, 1));
        if (flaw == FLAW_SECOND)
            frame[1] = second_start ^ 8'($urandom_range(255, 1));
        cut = (flaw == FLAW_TIMEOUT) ? $urandom_range(frame.size() - 1, 1) : -1;
        foreach (frame[i]) begin
            if (i == cut) begin
                feed(1'b1, 8'($urandom), 1'b1);
                break;
            end
            feed(1'b0, frame[i], 1'b1);
        end
    endtask

    task automatic random_burst();
        int r;
        r = $urandom_range(99);
        if (r < 75)
            send_frame(FLAW_NONE);
        else if (r < 83)
            send_frame(FLAW_SUM);
        else if (r < 87)
            send_frame(FLAW_SECOND);
        else if (r < 91)
            send_frame(FLAW_OVERSIZE);
        else if (r < 95)
            send_frame(FLAW_TIMEOUT);
        else
            repeat ($urandom_range(4, 1))
                feed($urandom_range(3) == 0, 8'($urandom), 1'b0);
    endtask

    task automatic set_start_bytes(input logic [7:0] a, input logic [7:0] b);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= pdac_pkg::CFG_FIRST_START;
        cfg_wr_data <= a;
        @(posedge aclk);
        cfg_addr    <= pdac_pkg::CFG_SECOND_START;
        cfg_wr_data <= b;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        first_start  = a;
        second_start = b;
    endtask

    // drop valid in the step of the last transfer, then let the drain finish
    task automatic settle(input int tail);
        s_tvalid <= 1'b0;
        while (pending_beats.size() != 0) @(posedge aclk);
        repeat (tail) @(posedge aclk);
    endtask

    initial begin
        int         n;
        logic [7:0] v;
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (script[i]) begin
            send_item(script[i].md, script[i].b, 1'b1, n);
            if (script[i].typed) begin
                if (script[i].one_beat)
                    pending_beats.push_back(script[i].beat);
            end else begin
                for (int k = 0; k < n; k++)
                    pending_beats.push_back(burst[k]);
            end
        end

        for (int p = 0; p < 5; p++) begin
            settle(8);
            case (p)
                1: set_start_bytes(8'h00, 8'hFF);
                2: begin
                    set_start_bytes(8'hFF, 8'h00);
                    pressure_go = 1'b1;
                end
                3: begin
                    v = 8'($urandom);
                    set_start_bytes(v, v);
                end
                4: set_start_bytes(8'($urandom), 8'($urandom));
                default: ;
            endcase
            no_gaps    = (p == 3);
            items_sent = 0;
            while (items_sent < 80)
                random_burst();
        end
        settle(20);

        if (mismatch_count == 0 && pending_beats.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

    // result side: random stalls, plus one long hold-off so the buffers fill
    initial begin
        int  hold_cycles;
        bit  held;
        hold_cycles = 0;
        held        = 1'b0;
        forever begin
            @(posedge aclk);
            if (pressure_go && !held) begin
                hold_cycles = 300;
                held        = 1'b1;
            end
            if (hold_cycles > 0) begin
                hold_cycles--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= no_gaps || ($urandom_range(99) >= 18);
            end
        end
    end

    always @(posedge aclk) begin
        beat_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (pending_beats.size() == 0) begin
                $error("result transfer with nothing expected: tdata %h", m_tdata);
                mismatch_count++;
            end else begin
                want = pending_beats.pop_front();
                check_field("msg_id", want.msg_id, m_tdata[7:0]);
                check_field("payload_len", want.payload_len, m_tdata[13:8]);
                check_field("byte_index", want.byte_index, m_tdata[18:14]);
                check_field("data_byte", want.data_byte, m_tdata[26:19]);
                check_field("tdata padding", 0, m_tdata[pdac_pkg::M_TDATA_W-1:27]);
                check_field("has_data", want.has_data, m_tuser);
                check_field("last", want.last, m_tlast);
            end
        end
    end

    initial begin
        #(12 * 400000);
        $display("end of test: mismatches");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
+incdir+rtl
rtl/pdac_pkg.sv
rtl/pdac_ram.sv
rtl/pdac_front.sv
rtl/pdac_queue.sv
rtl/pdac_back.sv
rtl/packet_deframer_additive_checksum.sv
tb/packet_deframer_additive_checksum_tb.sv
